// ----- rtl/core/cursor_sequence_buffer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Cursor sequence buffer: assertion macros
// Shared concurrent-assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_BUFFER_CORE_DEFINES_SVH
`define CURSOR_SEQUENCE_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/csb_pkg.sv -----
// ----------------------------------------------------------------------------
// Cursor sequence buffer package
// Sizes, request and status codes, cell commands and row control.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // request codes (codes 6 and 7 behave as status)
  localparam logic [2:0] REQ_START   = 3'd0;
  localparam logic [2:0] REQ_ADVANCE = 3'd1;
  localparam logic [2:0] REQ_INSERT  = 3'd2;
  localparam logic [2:0] REQ_ATTACH  = 3'd3;
  localparam logic [2:0] REQ_REMOVE  = 3'd4;
  localparam logic [2:0] REQ_STATUS  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CAPACITY-1:0][DATA_WIDTH-1:0] word_row_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ROW_HOLD,
    ROW_OPEN,   // open a gap at pos, load the new word there
    ROW_CLOSE   // drop the word at pos, upper words slide down
  } row_op_t;

  typedef struct packed {
    row_op_t          op;
    logic [IDX_W-1:0] pos;
    word_t            value;
  } row_ctrl_t;

endpackage

// ----- rtl/core/cursor_sequence_buffer_core.sv -----
// ----------------------------------------------------------------------------
// Cursor sequence buffer core
// Ordered word list with a cursor, kept in a shifting chain of cells.
// ----------------------------------------------------------------------------
// For each request, the list and cursor update at the edge that accepts
// the request; then, once the result register is free or being read, the
// word under the cursor is read out of the cell chain into the result
// register. Insert and attach open a gap by shifting every cell above the
// slot one place up in the same cycle; remove closes it by shifting down.
// The input takes a new request once the previous result sits in the
// result register, so a held result only stalls the block when a second
// result is ready behind it. Stored words have no reset; only positions
// below the count are ever read.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] entry_value
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [31:0] current_value, [32] has_item,
                                 // [38:33] item_count, [44:39] cursor_pos,
                                 // [46:45] status, [47] zero
);

  localparam int CNT_W = csb_pkg::CNT_W;
  localparam int IDX_W = csb_pkg::IDX_W;

  logic [CNT_W-1:0]   cursor, cursor_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [1:0]         status_next, pend_status;
  logic               pending;
  logic               accept;
  logic               present;
  logic               out_load;
  csb_pkg::row_ctrl_t ctrl;
  csb_pkg::word_row_t words;
  csb_pkg::word_t     cur_word;

  assign s_tready = !pending;
  assign accept   = s_tvalid && s_tready;
  assign present  = cursor < count;
  assign out_load = pending && (!m_tvalid || m_tready);

  // request decode; row is only driven on an accepted transfer
  always_comb begin
    cursor_next = cursor;
    count_next  = count;
    status_next = csb_pkg::ST_OK;
    ctrl.op     = csb_pkg::ROW_HOLD;
    ctrl.pos    = cursor[IDX_W-1:0];
    ctrl.value  = s_tdata[csb_pkg::DATA_WIDTH-1:0];
    case (s_tuser)
      csb_pkg::REQ_START: cursor_next = '0;
      csb_pkg::REQ_ADVANCE: begin
        if (!present) status_next = csb_pkg::ST_NONE;
        else          cursor_next = cursor + CNT_W'(1);
      end
      csb_pkg::REQ_INSERT, csb_pkg::REQ_ATTACH: begin
        if (count == CNT_W'(csb_pkg::CAPACITY)) begin
          status_next = csb_pkg::ST_FULL;
        end else begin
          // insert: before cursor, or front; attach: after cursor, or end
          if (s_tuser == csb_pkg::REQ_INSERT)
            ctrl.pos = present ? cursor[IDX_W-1:0] : '0;
          else
            ctrl.pos = present ? IDX_W'(cursor + CNT_W'(1)) : count[IDX_W-1:0];
          ctrl.op     = accept ? csb_pkg::ROW_OPEN : csb_pkg::ROW_HOLD;
          cursor_next = CNT_W'(ctrl.pos);
          count_next  = count + CNT_W'(1);
        end
      end
      csb_pkg::REQ_REMOVE: begin
        if (!present) begin
          status_next = csb_pkg::ST_NONE;
        end else begin
          ctrl.op    = accept ? csb_pkg::ROW_CLOSE : csb_pkg::ROW_HOLD;
          count_next = count - CNT_W'(1);
        end
      end
      default: ;  // status only
    endcase
  end

  csb_cell_row u_row (
    .clk   (clk),
    .ctrl  (ctrl),
    .words (words)
  );

  assign cur_word = present ? words[cursor[IDX_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      count    <= '0;
      pending  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cursor      <= cursor_next;
        count       <= count_next;
        pend_status <= status_next;
        pending     <= 1'b1;
      end else if (out_load) begin
        pending <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, pend_status, cursor, count, present, cur_word};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/csb_cell.sv -----
// ----------------------------------------------------------------------------
// Cursor sequence buffer cell
// One stored word; holds, loads, or takes a neighbor's word each cycle.
// ----------------------------------------------------------------------------
module csb_cell (
  input  logic              clk,
  input  csb_pkg::cell_cmd_t cmd,
  input  csb_pkg::word_t    load_value,
  input  csb_pkg::word_t    left,
  input  csb_pkg::word_t    right,
  output csb_pkg::word_t    word
);

  always_ff @(posedge clk) begin
    case (cmd)
      csb_pkg::CELL_LOAD:       word <= load_value;
      csb_pkg::CELL_FROM_LEFT:  word <= left;
      csb_pkg::CELL_FROM_RIGHT: word <= right;
      default:                  word <= word;
    endcase
  end

endmodule

// ----- rtl/core/csb_cell_row.sv -----
// ----------------------------------------------------------------------------
// Cursor sequence buffer cell row
// Chain of cells; each decodes its command from its index against pos.
// ----------------------------------------------------------------------------
module csb_cell_row (
  input  logic               clk,
  input  csb_pkg::row_ctrl_t ctrl,
  output csb_pkg::word_row_t words
);

  for (genvar i = 0; i < csb_pkg::CAPACITY; i++) begin : g_cell
    csb_pkg::cell_cmd_t cmd;
    csb_pkg::word_t     left;
    csb_pkg::word_t     right;
    logic               above;
    logic               at;

    assign above = csb_pkg::IDX_W'(i) > ctrl.pos;
    assign at    = csb_pkg::IDX_W'(i) == ctrl.pos;

    always_comb begin
      case (ctrl.op)
        csb_pkg::ROW_OPEN: begin
          if (above)   cmd = csb_pkg::CELL_FROM_LEFT;
          else if (at) cmd = csb_pkg::CELL_LOAD;
          else         cmd = csb_pkg::CELL_HOLD;
        end
        csb_pkg::ROW_CLOSE: begin
          cmd = (above || at) ? csb_pkg::CELL_FROM_RIGHT : csb_pkg::CELL_HOLD;
        end
        default: cmd = csb_pkg::CELL_HOLD;
      endcase
    end

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = words[i-1];
    end

    // top cell keeps its own word when the row closes
    if (i == csb_pkg::CAPACITY - 1) begin : g_last
      assign right = words[i];
    end else begin : g_mid_r
      assign right = words[i+1];
    end

    csb_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .load_value (ctrl.value),
      .left       (left),
      .right      (right),
      .word       (words[i])
    );
  end

endmodule

// ----- rtl/core/csb_checker.sv -----
// ----------------------------------------------------------------------------
// Cursor sequence buffer checker
// Port-level assertions on result consistency and request pacing.
// ----------------------------------------------------------------------------
`include "cursor_sequence_buffer_core_defines.svh"

module csb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  logic [5:0] cnt;
  logic [5:0] cur;
  logic [1:0] st;

  assign cnt = m_tdata[38:33];
  assign cur = m_tdata[44:39];
  assign st  = m_tdata[46:45];

  `CSB_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `CSB_ASSERT_NOW(a_has_item, m_tvalid, (m_tdata[32] == (cur < cnt)) && (cur <= cnt), "cursor and count disagree")
  `CSB_ASSERT_NOW(a_full_count, m_tvalid && (st == csb_pkg::ST_FULL), cnt == 6'(csb_pkg::CAPACITY), "full status below capacity")
  `CSB_ASSERT_NOW(a_empty_value, m_tvalid && !m_tdata[32], m_tdata[31:0] == 32'd0, "value without current item")
  `CSB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind cursor_sequence_buffer_core csb_checker u_csb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
